@@ src/alge_pkg.sv @@
package alge_pkg;

   localparam int FRAC_W      = 16;
   localparam int EXP2_STAGES = FRAC_W;
   localparam int LOG_STAGES  = FRAC_W;

   typedef logic csr_index_type;
   localparam csr_index_type CSR_DARK_CDF_LEVEL = 1'b0;
   localparam csr_index_type CSR_VALUE_STD_DEV  = 1'b1;

   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   typedef logic [19:0] logp_tab_type [256];
   typedef logic [20:0] logx_tab_type [256];
   typedef logic [30:0] coef_tab_type [EXP2_STAGES];

   // exp2 sideband, from the exponent split to the mantissa shift
   typedef struct packed {
      logic [7:0]        lin;
      logic [14:0]       t2;
      logic [5:0]        sh1;
      logic [5:0]        sh3;
      logic signed [6:0] esh;
   } side_a_type;

   // log sideband
   typedef struct packed {
      logic [7:0]  lin;
      logic [36:0] g;
      logic [4:0]  k;
      logic        zero;
   } side_b_type;

   // final power sideband
   typedef struct packed {
      logic [7:0] lin;
      logic [5:0] sh;
      logic       zero;
   } side_c_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(2^-(i+1)) in Q1.30
   function automatic coef_tab_type build_coef();
      coef_tab_type tab;
      logic [63:0]  c;
      c = isqrt64(64'd2 << 60);
      for (int i = 0; i < EXP2_STAGES; i++) begin
         tab[i] = c[30:0];
         c = isqrt64(c << 30);
      end
      return tab;
   endfunction

   // -log2(v/65536) in Q.16, v clamped to [1, 65536]
   function automatic logic [20:0] neg_log2_const(input logic [16:0] v_in);
      logic [63:0] v;
      logic [63:0] m;
      logic [15:0] frac;
      int          k;
      v = 64'(v_in);
      if (v == 64'd0) v = 64'd1;
      if (v > 64'd65536) v = 64'd65536;
      k = 0;
      for (int i = 0; i < 16; i++) begin
         if ((v >> (k + 1)) != 64'd0) k = k + 1;
      end
      m = v << (30 - k);
      frac = '0;
      for (int i = 1; i <= 16; i++) begin
         m = (m * m) >> 30;
         if (m >= 64'h8000_0000) begin
            m = m >> 1;
            frac[16-i] = 1'b1;
         end
      end
      return 21'(((16 - k) * 65536) - int'(frac));
   endfunction

   function automatic logp_tab_type build_logp();
      logp_tab_type tab;
      for (int v = 0; v < 256; v++) begin
         tab[v] = 20'(neg_log2_const(17'((v + 1) * 256)));
      end
      return tab;
   endfunction

   function automatic logx_tab_type build_logx();
      logx_tab_type tab;
      for (int v = 0; v < 256; v++) begin
         tab[v] = neg_log2_const(17'(v * 257 + v / 128));
      end
      return tab;
   endfunction

   localparam coef_tab_type EXP2_COEF = build_coef();
   localparam logp_tab_type LOGP_TAB  = build_logp();
   localparam logx_tab_type LOGX_TAB  = build_logx();

endpackage

@@ src/alge_exp2.sv @@
module alge_exp2 (
   input  logic        clock,
   input  logic        enable,
   input  logic [15:0] frac_bits,
   output logic [30:0] mant
);
   import alge_pkg::*;

   logic [30:0] mant_ff [EXP2_STAGES];
   logic [15:0] frac_ff [EXP2_STAGES-1];
   logic [30:0] mant_in [EXP2_STAGES];
   logic [61:0] prod    [EXP2_STAGES];

   // one fraction bit per stage, msb first
   always_comb begin
      prod[0]    = '0;
      mant_in[0] = frac_bits[FRAC_W-1] ? EXP2_COEF[0] : ONE_Q30;
      for (int j = 1; j < EXP2_STAGES; j++) begin
         prod[j] = 62'(mant_ff[j-1]) * 62'(EXP2_COEF[j]) + (62'd1 << 29);
         mant_in[j] = frac_ff[j-1][FRAC_W-1-j] ? prod[j][60:30] : mant_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         frac_ff[0] <= frac_bits;
         for (int j = 1; j < EXP2_STAGES-1; j++) begin
            frac_ff[j] <= frac_ff[j-1];
         end
         for (int j = 0; j < EXP2_STAGES; j++) begin
            mant_ff[j] <= mant_in[j];
         end
      end
   end

   assign mant = mant_ff[EXP2_STAGES-1];

endmodule

@@ src/adaptive_local_gamma_enhance.sv @@
// Per-pixel brightness enhancement of the HSV value channel. Each word carries a pixel
// and its blurred neighbourhood value and yields one enhanced value; words are independent,
// so one is taken every clock while the output is not held; the data path runs through
// two 16-stage exp2 multiplier chains and one 16-stage log2 squaring chain in series
// (the first exp2 level runs three chains side by side).
// The whole pipeline holds while a finished result waits at the output register. The
// csr_ port sets the 10% CDF level (index 0) and the standard deviation (index 1); write it
// only while no word is in flight.
module adaptive_local_gamma_enhance (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_pixel_value,
   input  logic [7:0]             req_blurred_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_enhanced_value,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  alge_pkg::csr_index_type csr_index,
   input  logic [10:0]            csr_data
);
   import alge_pkg::*;

   localparam int S_A       = 3;
   localparam int S_T       = S_A + EXP2_STAGES + 1;
   localparam int S_I1      = S_T + 1;
   localparam int S_LG0     = S_I1 + 1;
   localparam int S_LG_OUT  = S_LG0 + LOG_STAGES;
   localparam int S_F       = S_LG_OUT + 4;
   localparam int S_PW      = S_F + EXP2_STAGES + 1;
   localparam int LAST      = S_PW + 1;

   localparam logic [18:0] Z_RECIP  = 19'd372828;
   localparam logic [17:0] P_RECIP  = 18'd149797;
   localparam logic [18:0] T2_RECIP = 19'd419431;

   // ---------------- configuration ----------------
   logic [12:0] e1_ff, e1_in;
   logic [13:0] e2_ff, e2_in;
   logic [12:0] zc_ff, zc_in;
   logic [13:0] p_ff, p_in;
   logic [12:0] z_new;
   logic [17:0] znum;
   logic [36:0] zmul;
   logic [11:0] pa;
   logic [16:0] pnum;
   logic [34:0] pmul;

   assign csr_ready = 1'b1;

   always_comb begin
      znum = 18'((18'(csr_data[7:0]) - 18'd5) << 12) + 18'd22;
      zmul = 37'(znum) * 37'(Z_RECIP);
      if (csr_data[7:0] <= 8'd5) begin
         z_new = '0;
      end else if (csr_data[7:0] <= 8'd50) begin
         z_new = 13'(zmul >> 24);
      end else begin
         z_new = 13'd4096;
      end
      e1_in = 13'((14'(z_new) * 14'd3 + 14'd2) >> 2) + 13'd1024;
      e2_in = 14'd8192 - 14'(z_new);
      zc_in = 13'd4096 - z_new;
      pa    = 12'd432 - {csr_data, 1'b0};
      pnum  = {pa[8:0], 8'h00} + 17'd3;
      pmul  = 35'(pnum) * 35'(P_RECIP);
      if (csr_data <= 11'd48) begin
         p_in = 14'd12288;
      end else if (csr_data <= 11'd160) begin
         p_in = 14'(pmul >> 20);
      end else begin
         p_in = 14'd4096;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_ff <= 13'd1024;
         e2_ff <= 14'd8192;
         zc_ff <= 13'd4096;
         p_ff  <= 14'd12288;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DARK_CDF_LEVEL: begin
               e1_ff <= e1_in;
               e2_ff <= e2_in;
               zc_ff <= zc_in;
            end
            CSR_VALUE_STD_DEV: begin
               p_ff <= p_in;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- flow control ----------------
   logic [LAST:1] vld_ff;
   logic          adv;

   assign adv       = !vld_ff[LAST] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAST-1:1], req_valid};
      end
   end

   // ---------------- stage 1: tables ----------------
   logic [7:0]  lin1_ff;
   logic [16:0] x1_ff, x1_in;
   logic [20:0] nlx1_ff;
   logic        dneg1_ff, dneg1_in;
   logic [19:0] dmag1_ff, dmag1_in;
   logic [19:0] lm, bm;

   always_comb begin
      lm       = LOGP_TAB[req_pixel_value];
      bm       = LOGP_TAB[req_blurred_value];
      x1_in    = 17'(req_pixel_value) * 17'd257 + 17'(req_pixel_value[7]);
      dneg1_in = lm < bm;
      dmag1_in = dneg1_in ? bm - lm : lm - bm;
   end

   // ---------------- stage 2: exponent products ----------------
   logic [7:0]  lin2_ff;
   logic [28:0] w2_ff, w2_in;
   logic [20:0] q1_2_ff, q1_2_in;
   logic [21:0] q3_2_ff, q3_2_in;
   logic        eneg2_ff;
   logic [20:0] mq2_ff, mq2_in;
   logic [33:0] pq1, pq3, pmq;

   always_comb begin
      pq1     = 34'(nlx1_ff) * 34'(e1_ff) + 34'd2048;
      pq3     = 34'(nlx1_ff) * 34'(e2_ff) + 34'd2048;
      pmq     = 34'(dmag1_ff) * 34'(p_ff) + 34'd2048;
      q1_2_in = 21'(pq1 >> 12);
      q3_2_in = 22'(pq3 >> 12);
      mq2_in  = 21'(pmq >> 12);
      w2_in   = 29'((17'd65536 - x1_ff) * 30'(zc_ff));
   end

   // ---------------- stage 3: split exponents ----------------
   logic [15:0] f1_ff, f1_in, f3_ff, f3_in, fe_ff, fe_in;
   side_a_type  side_a_ff [EXP2_STAGES+1];
   side_a_type  side_a_in;
   logic [17:0] t2n;
   logic [36:0] t2mul;
   logic        nz1, nz3, nze;

   always_comb begin
      t2n   = 18'((30'(w2_ff) + 30'd5120) >> 11);
      t2mul = 37'(t2n) * 37'(T2_RECIP);
      nz1   = q1_2_ff[15:0] != 16'd0;
      nz3   = q3_2_ff[15:0] != 16'd0;
      nze   = mq2_ff[15:0] != 16'd0;
      f1_in = 16'(17'd0 - 17'(q1_2_ff[15:0]));
      f3_in = 16'(17'd0 - 17'(q3_2_ff[15:0]));
      side_a_in.lin = lin2_ff;
      side_a_in.t2  = 15'(t2mul >> 21);
      side_a_in.sh1 = 6'd14 + 6'(q1_2_ff[20:16]) + 6'(nz1);
      side_a_in.sh3 = 6'd14 + q3_2_ff[21:16] + 6'(nz3);
      if (eneg2_ff) begin
         fe_in = 16'(17'd0 - 17'(mq2_ff[15:0]));
         side_a_in.esh = 7'sd18 + $signed({2'b00, mq2_ff[20:16]}) + $signed({6'd0, nze});
      end else begin
         fe_in = mq2_ff[15:0];
         side_a_in.esh = 7'sd18 - $signed({2'b00, mq2_ff[20:16]});
      end
   end

   logic [30:0] mant1, mant3, mante, mantp;

   alge_exp2 u_exp_t1 (.clock(clock), .enable(adv), .frac_bits(f1_ff), .mant(mant1));
   alge_exp2 u_exp_t3 (.clock(clock), .enable(adv), .frac_bits(f3_ff), .mant(mant3));
   alge_exp2 u_exp_e  (.clock(clock), .enable(adv), .frac_bits(fe_ff), .mant(mante));

   // ---------------- stage T: scale the powers ----------------
   side_a_type  sa;
   logic [47:0] r1w, r3w, rew;
   logic [16:0] t1_ff, t1_in, t3_ff, t3_in;
   logic [36:0] e_ff, e_in;
   logic [14:0] t2t_ff;
   logic [7:0]  lint_ff;
   logic [5:0]  lsh;

   always_comb begin
      sa  = side_a_ff[EXP2_STAGES];
      r1w = (48'(mant1) + (48'd1 << (sa.sh1 - 6'd1))) >> sa.sh1;
      r3w = (48'(mant3) + (48'd1 << (sa.sh3 - 6'd1))) >> sa.sh3;
      t1_in = (sa.lin == 8'd0) ? 17'd0 : r1w[16:0];
      t3_in = (sa.lin == 8'd0) ? 17'd0 : r3w[16:0];
      lsh = 6'(-sa.esh);
      if (sa.esh <= 7'sd0) begin
         rew  = '0;
         e_in = 37'(mante) << lsh;
      end else begin
         rew  = (48'(mante) + (48'd1 << (sa.esh - 7'sd1))) >> sa.esh;
         e_in = rew[36:0];
      end
   end

   // ---------------- stage I1: mix and gamma ----------------
   logic [16:0] i1_ff, i1_in;
   logic [36:0] g_ff, g_in;
   logic [7:0]  lini_ff;
   logic [17:0] isum;
   logic [48:0] gmul;

   always_comb begin
      isum  = 18'(t1_ff) + 18'(t2t_ff) + 18'(t3_ff) + 18'd1;
      i1_in = (isum[17:1] > 17'd65536) ? 17'd65536 : isum[17:1];
      gmul  = 49'(e_ff) * 49'd3686 + 49'd2048;
      g_in  = 37'(gmul >> 12);
   end

   // ---------------- log2 of I1: normalise, then squaring chain ----------------
   logic [30:0] lg_m_ff [LOG_STAGES+1];
   logic [15:0] lg_f_ff [LOG_STAGES+1];
   logic [30:0] lg_m_in [LOG_STAGES+1];
   logic [15:0] lg_f_in [LOG_STAGES+1];
   logic [61:0] sq      [LOG_STAGES+1];
   side_b_type  side_b_ff [LOG_STAGES+1];
   side_b_type  side_b_in;
   logic [16:0] nv;
   logic [4:0]  lead;
   logic [46:0] nshift;

   always_comb begin
      nv   = (i1_ff == 17'd0) ? 17'd1 : i1_ff;
      lead = '0;
      for (int i = 0; i < 17; i++) begin
         if (nv[i]) lead = 5'(i);
      end
      nshift = 47'(nv) << (5'd30 - lead);
      lg_m_in[0] = nshift[30:0];
      lg_f_in[0] = '0;
      sq[0]      = '0;
      side_b_in.lin  = lini_ff;
      side_b_in.g    = g_ff;
      side_b_in.k    = lead;
      side_b_in.zero = i1_ff == 17'd0;
      for (int j = 1; j <= LOG_STAGES; j++) begin
         sq[j]      = 62'(lg_m_ff[j-1]) * 62'(lg_m_ff[j-1]);
         lg_f_in[j] = lg_f_ff[j-1];
         if (sq[j][61]) begin
            lg_m_in[j] = sq[j][61:31];
            lg_f_in[j][FRAC_W-j] = 1'b1;
         end else begin
            lg_m_in[j] = sq[j][60:30];
         end
      end
   end

   // ---------------- -log2 result, exponent product ----------------
   side_b_type  sb;
   logic [20:0] nl_ff, nl_in;
   logic [36:0] gn_ff;
   logic [7:0]  linn_ff, linp_ff, linq_ff;
   logic        zn_ff, zp_ff, zq_ff;
   logic [39:0] plo_ff, plo_in;
   logic [38:0] phi_ff, phi_in;
   logic [45:0] q_ff, q_in;
   logic [58:0] qsum;

   always_comb begin
      sb     = side_b_ff[LOG_STAGES];
      nl_in  = (21'(5'd16 - sb.k) << 16) - 21'(lg_f_ff[LOG_STAGES]);
      plo_in = 40'(nl_ff) * 40'(gn_ff[18:0]);
      phi_in = 39'(nl_ff) * 39'(gn_ff[36:19]);
      qsum   = 59'(plo_ff) + (59'(phi_ff) << 19) + 59'd2048;
      q_in   = 46'(qsum >> 12);
   end

   // ---------------- split the final exponent ----------------
   logic [15:0] fp_ff, fp_in;
   side_c_type  side_c_ff [EXP2_STAGES+1];
   side_c_type  side_c_in;
   logic        nzp;
   logic [30:0] np;

   always_comb begin
      nzp   = q_ff[15:0] != 16'd0;
      fp_in = 16'(17'd0 - 17'(q_ff[15:0]));
      np    = 31'(q_ff[45:16]) + 31'(nzp);
      side_c_in.lin  = linq_ff;
      side_c_in.zero = zq_ff || (np >= 31'd49);
      side_c_in.sh   = 6'(np + 31'd14);
   end

   alge_exp2 u_exp_p (.clock(clock), .enable(adv), .frac_bits(fp_ff), .mant(mantp));

   // ---------------- scale, compare, output ----------------
   side_c_type  sc;
   logic [63:0] rpw;
   logic [16:0] pw_ff, pw_in;
   logic [7:0]  linw_ff;
   logic [7:0]  out_ff, out_in;
   logic [24:0] val;
   logic [25:0] vtest;

   always_comb begin
      sc    = side_c_ff[EXP2_STAGES];
      rpw   = (64'(mantp) + (64'd1 << (sc.sh - 6'd1))) >> sc.sh;
      pw_in = sc.zero ? 17'd0 : rpw[16:0];
      val   = (25'(pw_ff) << 8) - 25'(pw_ff);
      vtest = 26'(val) + 26'd65536;
      // doubled pixel unless the curve value sits at least one below it
      if (vtest <= (26'(linw_ff) << 17)) begin
         out_in = val[23:16];
      end else begin
         out_in = {linw_ff[6:0], 1'b0};
      end
   end

   assign rsp_enhanced_value = out_ff;

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      if (adv) begin
         lin1_ff  <= req_pixel_value;
         x1_ff    <= x1_in;
         nlx1_ff  <= LOGX_TAB[req_pixel_value];
         dneg1_ff <= dneg1_in;
         dmag1_ff <= dmag1_in;

         lin2_ff  <= lin1_ff;
         w2_ff    <= w2_in;
         q1_2_ff  <= q1_2_in;
         q3_2_ff  <= q3_2_in;
         eneg2_ff <= dneg1_ff;
         mq2_ff   <= mq2_in;

         f1_ff <= f1_in;
         f3_ff <= f3_in;
         fe_ff <= fe_in;
         side_a_ff[0] <= side_a_in;
         for (int j = 1; j <= EXP2_STAGES; j++) begin
            side_a_ff[j] <= side_a_ff[j-1];
         end

         t1_ff   <= t1_in;
         t3_ff   <= t3_in;
         e_ff    <= e_in;
         t2t_ff  <= sa.t2;
         lint_ff <= sa.lin;

         i1_ff   <= i1_in;
         g_ff    <= g_in;
         lini_ff <= lint_ff;

         for (int j = 0; j <= LOG_STAGES; j++) begin
            lg_m_ff[j] <= lg_m_in[j];
            lg_f_ff[j] <= lg_f_in[j];
         end
         side_b_ff[0] <= side_b_in;
         for (int j = 1; j <= LOG_STAGES; j++) begin
            side_b_ff[j] <= side_b_ff[j-1];
         end

         nl_ff   <= nl_in;
         gn_ff   <= sb.g;
         linn_ff <= sb.lin;
         zn_ff   <= sb.zero;

         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         linp_ff <= linn_ff;
         zp_ff   <= zn_ff;

         q_ff    <= q_in;
         linq_ff <= linp_ff;
         zq_ff   <= zp_ff;

         fp_ff        <= fp_in;
         side_c_ff[0] <= side_c_in;
         for (int j = 1; j <= EXP2_STAGES; j++) begin
            side_c_ff[j] <= side_c_ff[j-1];
         end

         pw_ff   <= pw_in;
         linw_ff <= sc.lin;

         out_ff <= out_in;
      end
   end

   // ---------------- checks ----------------
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline valids moved during a stall");

   a_exp_norm: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_T-1] |-> (mant1[30] && mant3[30] && mante[30]))
      else $error("exp2 mantissa not normalised");

   a_log_norm: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_LG_OUT] |-> (lg_m_ff[0][30] && lg_m_ff[LOG_STAGES][30]))
      else $error("log2 mantissa lost its leading one");

   a_i1_cap: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_LG0] |-> (side_b_ff[0].zero == (lg_m_ff[0] == ONE_Q30 && side_b_ff[0].k == 5'd0)
                         || !side_b_ff[0].zero))
      else $error("zero mix value not flagged");

   a_pow_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] |-> pw_ff <= 17'd65536)
      else $error("final power above one");

   a_p_range: assert property (@(posedge clock) disable iff (reset)
      (p_ff >= 14'd4096) && (p_ff <= 14'd12288) && (zc_ff <= 13'd4096))
      else $error("contrast exponent or mix factor out of range");

endmodule
